@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
// needs clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mdsg_pkg.sv @@
// types, constants and helper functions of the markov dna sequence generator
// no dependencies
package mdsg_pkg;

    localparam int MAX_ORDER_DEF = 3;
    localparam int TBL_ROWS      = 85;
    localparam int TBL_COLS      = 3;
    localparam int ROW_W         = 7;
    localparam int COL_W         = 2;
    localparam int BND_W         = 33;
    localparam int WORD_W        = 32;
    localparam int SEED_W        = 64;
    localparam int SEED_WORDS    = 4;
    localparam int XO_SHIFT      = 9;
    localparam int XO_ROT        = 11;

    localparam logic [SEED_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [SEED_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [SEED_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

    localparam logic [ROW_W-1:0] ROW_START [4] = '{7'd0, 7'd1, 7'd5, 7'd21};

    typedef logic [TBL_COLS-1:0][BND_W-1:0] bnd_row_t;
    typedef logic [SEED_WORDS-1:0][WORD_W-1:0] rng_words_t;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_START = 2'd1,
        MODE_GEN   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SEED,
        TOP_GEN
    } top_state_t;

    typedef enum logic [2:0] {
        SD_IDLE,
        SD_ADD,
        SD_M0,
        SD_M1,
        SD_M2,
        SD_M3,
        SD_DONE
    } seed_state_t;

    function automatic logic [7:0] base_to_letter(input logic [1:0] code);
        logic [7:0] letter;
        case (code)
            2'd0:    letter = 8'h41;
            2'd1:    letter = 8'h43;
            2'd2:    letter = 8'h47;
            default: letter = 8'h54;
        endcase
        return letter;
    endfunction

endpackage

@@ hw/rtl/mdsg_bnd_table.sv @@
// boundary table: 85 rows of three 33-bit cumulative boundaries
// one column write port, one registered row read port; uses mdsg_pkg
module mdsg_bnd_table
(
    input  logic                                clk,
    input  logic                                we,
    input  logic [mdsg_pkg::ROW_W-1:0]          wrow,
    input  logic [mdsg_pkg::COL_W-1:0]          wcol,
    input  logic [mdsg_pkg::BND_W-1:0]          wdata,
    input  logic                                re,
    input  logic [mdsg_pkg::ROW_W-1:0]          rrow,
    output mdsg_pkg::bnd_row_t                  rdata
);

    mdsg_pkg::bnd_row_t bnd_mem [mdsg_pkg::TBL_ROWS];
    mdsg_pkg::bnd_row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bnd_mem[wrow][wcol] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= bnd_mem[rrow];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mdsg_seeder.sv @@
// splitmix64 seeding sequencer around one shared registered 32x32 multiplier
// produces the four generator words of a sequence; uses mdsg_pkg
module mdsg_seeder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mdsg_pkg::SEED_W-1:0]         seed_base,
    input  logic [mdsg_pkg::WORD_W-1:0]         seq_index,
    output logic                                done,
    output mdsg_pkg::rng_words_t                words
);

    localparam int CNT_W = $clog2(mdsg_pkg::SEED_WORDS + 1);
    localparam int HW    = mdsg_pkg::SEED_W / 2;

    mdsg_pkg::seed_state_t state_reg, state_next;

    logic [mdsg_pkg::SEED_W-1:0] s_reg, s_next;
    logic [mdsg_pkg::SEED_W-1:0] z_reg, z_next;
    logic [mdsg_pkg::SEED_W-1:0] acc_reg, acc_next;
    logic [mdsg_pkg::SEED_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        sel_reg, sel_next;
    mdsg_pkg::rng_words_t        words_reg, words_next;

    logic [mdsg_pkg::SEED_W-1:0] mul_c;
    logic [HW-1:0]               mul_a, mul_b;
    logic [mdsg_pkg::SEED_W-1:0] s_add;
    logic [mdsg_pkg::SEED_W-1:0] t_prod;
    logic [mdsg_pkg::SEED_W-1:0] t_mix;
    logic [CNT_W-1:0]            cnt_last;
    logic [1:0]                  word_idx;

    assign mul_c    = sel_reg ? mdsg_pkg::SM_MUL2 : mdsg_pkg::SM_MUL1;
    assign s_add    = s_reg + mdsg_pkg::SM_GAMMA;
    assign t_prod   = {acc_reg[mdsg_pkg::SEED_W-1:HW] + prod_reg[HW-1:0], acc_reg[HW-1:0]};
    assign t_mix    = t_prod ^ (t_prod >> 31);
    assign cnt_last = CNT_W'(mdsg_pkg::SEED_WORDS);
    assign word_idx = 2'(cnt_reg - CNT_W'(1));

    // operand select for the shared multiplier: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        mul_a = z_reg[HW-1:0];
        mul_b = mul_c[HW-1:0];
        case (state_reg)
            mdsg_pkg::SD_M1:
            begin
                mul_b = mul_c[mdsg_pkg::SEED_W-1:HW];
            end
            mdsg_pkg::SD_M2:
            begin
                mul_a = z_reg[mdsg_pkg::SEED_W-1:HW];
            end
            default:
            begin
            end
        endcase
    end

    assign prod_next = mdsg_pkg::SEED_W'(mul_a) * mdsg_pkg::SEED_W'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdsg_pkg::SD_IDLE: if (start) state_next = mdsg_pkg::SD_ADD;
            mdsg_pkg::SD_ADD:  state_next = mdsg_pkg::SD_M0;
            mdsg_pkg::SD_M0:   state_next = mdsg_pkg::SD_M1;
            mdsg_pkg::SD_M1:   state_next = mdsg_pkg::SD_M2;
            mdsg_pkg::SD_M2:   state_next = mdsg_pkg::SD_M3;
            mdsg_pkg::SD_M3:
            begin
                if (!sel_reg)
                    state_next = mdsg_pkg::SD_M0;
                else if (cnt_reg == cnt_last)
                    state_next = mdsg_pkg::SD_DONE;
                else
                    state_next = mdsg_pkg::SD_ADD;
            end
            mdsg_pkg::SD_DONE: state_next = mdsg_pkg::SD_IDLE;
            default:           state_next = mdsg_pkg::SD_IDLE;
        endcase
    end

    always_comb
    begin
        s_next     = s_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        words_next = words_reg;
        done       = 1'b0;
        unique case (state_reg)
            mdsg_pkg::SD_IDLE:
            begin
                if (start)
                begin
                    s_next   = seed_base + mdsg_pkg::SEED_W'(seq_index);
                    cnt_next = '0;
                end
            end
            mdsg_pkg::SD_ADD:
            begin
                s_next   = s_add;
                z_next   = s_add ^ (s_add >> 30);
                sel_next = 1'b0;
            end
            mdsg_pkg::SD_M0:
            begin
            end
            mdsg_pkg::SD_M1:
            begin
                acc_next = prod_reg;
            end
            mdsg_pkg::SD_M2:
            begin
                acc_next[mdsg_pkg::SEED_W-1:HW] =
                    acc_reg[mdsg_pkg::SEED_W-1:HW] + prod_reg[HW-1:0];
            end
            mdsg_pkg::SD_M3:
            begin
                if (!sel_reg)
                begin
                    z_next   = t_prod ^ (t_prod >> 27);
                    sel_next = 1'b1;
                end
                else if (cnt_reg == '0)
                begin
                    s_next   = t_mix;
                    cnt_next = CNT_W'(1);
                end
                else
                begin
                    words_next[word_idx] = t_mix[HW-1:0] ^ t_mix[mdsg_pkg::SEED_W-1:HW];
                    cnt_next             = cnt_reg + CNT_W'(1);
                end
            end
            mdsg_pkg::SD_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdsg_pkg::SD_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        words_reg <= words_next;
    end

    assign words = words_reg;

endmodule

@@ hw/rtl/markov_dna_sequence_generator.sv @@
// markov dna sequence generator: table writes, base generation and stream starts (a
// start runs five splitmix64 steps, each two 64-bit products made of three passes
// through the shared 32x32 multiplier); one request in work at a time
// reset clears seed base, generator words, context and order; table is undefined
// until written; uses mdsg_pkg, mdsg_bnd_table, mdsg_seeder and assert_macros.svh
`include "assert_macros.svh"

module markov_dna_sequence_generator
#(
    parameter int MAX_ORDER = mdsg_pkg::MAX_ORDER_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mdsg_pkg::SEED_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [mdsg_pkg::ROW_W-1:0]          table_row,
    input  logic [mdsg_pkg::COL_W-1:0]          table_column,
    input  logic [mdsg_pkg::BND_W-1:0]          boundary_value,
    input  logic [mdsg_pkg::WORD_W-1:0]         sequence_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          base_code,
    output logic [7:0]                          base_letter
);

    localparam int CTX_W = 2 * MAX_ORDER;

    mdsg_pkg::top_state_t state_reg, state_next;

    logic [mdsg_pkg::SEED_W-1:0] seed_base_reg;
    mdsg_pkg::rng_words_t        rng_reg, rng_next;
    logic [CTX_W-1:0]            ctx_reg, ctx_next;
    logic [1:0]                  order_reg, order_next;
    logic [mdsg_pkg::WORD_W-1:0] w_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  base_code_reg;
    logic [7:0]                  base_letter_reg;

    logic                        in_acc;
    logic                        tbl_we;
    logic                        rd_en;
    logic                        seed_start;
    logic                        gen_load;
    logic                        seed_done;
    mdsg_pkg::rng_words_t        seed_words;
    mdsg_pkg::bnd_row_t          bnd_row;
    logic [mdsg_pkg::ROW_W:0]    row_sum;
    logic [mdsg_pkg::ROW_W-1:0]  rd_row;
    logic [mdsg_pkg::WORD_W-1:0] xo_w;
    mdsg_pkg::rng_words_t        xo_step;
    logic [mdsg_pkg::WORD_W-1:0] xo_t, xo_r2, xo_r3;
    logic [mdsg_pkg::BND_W-1:0]  w_ext;
    logic [1:0]                  sym;
    logic [CTX_W+1:0]            ctx_shift;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == mdsg_pkg::TOP_IDLE);
    assign in_acc    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_base_reg <= '0;
        else if (cfg_valid && cfg_ready)
            seed_base_reg <= cfg_data;
    end

    // row of the current context, clamped to the last row
    assign row_sum = (mdsg_pkg::ROW_W + 1)'(mdsg_pkg::ROW_START[order_reg])
                   + (mdsg_pkg::ROW_W + 1)'(ctx_reg);
    assign rd_row  = (row_sum >= (mdsg_pkg::ROW_W + 1)'(mdsg_pkg::TBL_ROWS))
                   ? mdsg_pkg::ROW_W'(mdsg_pkg::TBL_ROWS - 1)
                   : row_sum[mdsg_pkg::ROW_W-1:0];

    mdsg_bnd_table u_table
    (
        .clk   (clk),
        .we    (tbl_we),
        .wrow  (table_row),
        .wcol  (table_column),
        .wdata (boundary_value),
        .re    (rd_en),
        .rrow  (rd_row),
        .rdata (bnd_row)
    );

    mdsg_seeder u_seeder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seed_start),
        .seed_base (seed_base_reg),
        .seq_index (sequence_index),
        .done      (seed_done),
        .words     (seed_words)
    );

    // xoshiro128+ step
    assign xo_w  = rng_reg[0] + rng_reg[3];
    assign xo_t  = rng_reg[1] << mdsg_pkg::XO_SHIFT;
    assign xo_r2 = rng_reg[2] ^ rng_reg[0];
    assign xo_r3 = rng_reg[3] ^ rng_reg[1];

    always_comb
    begin
        xo_step[1] = rng_reg[1] ^ xo_r2;
        xo_step[0] = rng_reg[0] ^ xo_r3;
        xo_step[2] = xo_r2 ^ xo_t;
        xo_step[3] = {xo_r3[mdsg_pkg::WORD_W-1-mdsg_pkg::XO_ROT:0],
                      xo_r3[mdsg_pkg::WORD_W-1:mdsg_pkg::WORD_W-mdsg_pkg::XO_ROT]};
    end

    // base select from the three boundaries
    assign w_ext = mdsg_pkg::BND_W'(w_reg);

    always_comb
    begin
        if (w_ext < bnd_row[1])
            sym = (w_ext < bnd_row[0]) ? 2'd0 : 2'd1;
        else
            sym = (w_ext < bnd_row[2]) ? 2'd2 : 2'd3;
    end

    assign ctx_shift = {ctx_reg, sym};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mdsg_pkg::TOP_IDLE:
            begin
                if (in_acc && mode == mdsg_pkg::MODE_START)
                    state_next = mdsg_pkg::TOP_SEED;
                else if (in_acc && mode == mdsg_pkg::MODE_GEN)
                    state_next = mdsg_pkg::TOP_GEN;
            end
            mdsg_pkg::TOP_SEED:
            begin
                if (seed_done)
                    state_next = mdsg_pkg::TOP_IDLE;
            end
            mdsg_pkg::TOP_GEN:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = mdsg_pkg::TOP_IDLE;
            end
            default:
            begin
                state_next = mdsg_pkg::TOP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tbl_we     = 1'b0;
        rd_en      = 1'b0;
        seed_start = 1'b0;
        gen_load   = 1'b0;
        unique case (state_reg)
            mdsg_pkg::TOP_IDLE:
            begin
                tbl_we     = in_acc && mode == mdsg_pkg::MODE_WRITE
                          && table_row < mdsg_pkg::ROW_W'(mdsg_pkg::TBL_ROWS)
                          && table_column < mdsg_pkg::COL_W'(mdsg_pkg::TBL_COLS);
                rd_en      = in_acc && mode == mdsg_pkg::MODE_GEN;
                seed_start = in_acc && mode == mdsg_pkg::MODE_START;
            end
            mdsg_pkg::TOP_SEED:
            begin
            end
            mdsg_pkg::TOP_GEN:
            begin
                gen_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rng_next       = rng_reg;
        ctx_next       = ctx_reg;
        order_next     = order_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (rd_en)
            rng_next = xo_step;
        if (state_reg == mdsg_pkg::TOP_SEED && seed_done)
        begin
            rng_next   = seed_words;
            // an all-zero state would lock the generator
            if (seed_words == '0)
                rng_next[0] = mdsg_pkg::WORD_W'(1);
            ctx_next   = '0;
            order_next = '0;
        end
        if (gen_load)
        begin
            ctx_next       = ctx_shift[CTX_W-1:0];
            out_valid_next = 1'b1;
            if (order_reg < 2'(MAX_ORDER))
                order_next = order_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdsg_pkg::TOP_IDLE;
            rng_reg       <= '0;
            ctx_reg       <= '0;
            order_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rng_reg       <= rng_next;
            ctx_reg       <= ctx_next;
            order_reg     <= order_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            w_reg <= xo_w;
        if (gen_load)
        begin
            base_code_reg   <= sym;
            base_letter_reg <= mdsg_pkg::base_to_letter(sym);
        end
    end

    assign out_valid   = out_valid_reg;
    assign base_code   = base_code_reg;
    assign base_letter = base_letter_reg;

    `ASSERT_NXT(a_gen_enters_cmp, in_acc && mode == mdsg_pkg::MODE_GEN, state_reg == mdsg_pkg::TOP_GEN, "generate request did not reach compare")
    `ASSERT_IMP(a_seed_done_state, seed_done, state_reg == mdsg_pkg::TOP_SEED, "seeder finished outside seed state")
    `ASSERT_NXT(a_seed_nonzero, state_reg == mdsg_pkg::TOP_SEED && seed_done, rng_reg != '0, "generator state zero after start")
    `ASSERT_IMP(a_result_from_gen, $rose(out_valid_reg), $past(state_reg) == mdsg_pkg::TOP_GEN, "result raised outside compare")

endmodule

@@ tb/sv/testbench.sv @@
// testbench of markov_dna_sequence_generator: table writes, stream starts and base draws
// with random gaps and stalls, each base checked against an in-bench predictor
// depends on mdsg_pkg and the rtl of markov_dna_sequence_generator
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 560;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [mdsg_pkg::BND_W-1:0] BND_FULL = 33'h1_0000_0000;
    localparam logic [31:0] LETTERS = "ACGT";

    typedef struct packed
    {
        logic [1:0] code;
        logic [7:0] letter;
    } base_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mdsg_pkg::SEED_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    mdsg_pkg::mode_t mode = mdsg_pkg::MODE_NONE;
    logic [mdsg_pkg::ROW_W-1:0] table_row = '0;
    logic [mdsg_pkg::COL_W-1:0] table_column = '0;
    logic [mdsg_pkg::BND_W-1:0] boundary_value = '0;
    logic [mdsg_pkg::WORD_W-1:0] sequence_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] base_code;
    logic [7:0] base_letter;

    // predictor state
    logic [mdsg_pkg::SEED_W-1:0] seed_base = '0;
    logic [mdsg_pkg::BND_W-1:0] bnd_tbl [mdsg_pkg::TBL_ROWS][mdsg_pkg::TBL_COLS];
    logic [mdsg_pkg::WORD_W-1:0] rng_state [mdsg_pkg::SEED_WORDS] = '{default: '0};
    logic [2*mdsg_pkg::MAX_ORDER_DEF-1:0] ctx_bits = '0;
    logic [1:0] ctx_order = '0;

    base_t expected_bases [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit sender_idles = 1'b1;
    bit receiver_stalls = 1'b1;
    int stall_left = 0;

    markov_dna_sequence_generator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .table_row      (table_row),
        .table_column   (table_column),
        .boundary_value (boundary_value),
        .sequence_index (sequence_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .base_code      (base_code),
        .base_letter    (base_letter)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("markov_dna_sequence_generator test failed");
            $finish;
        end
    end

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (receiver_stalls && $urandom_range(0, 99) < 20)
        begin
            out_ready <= 1'b0;
            stall_left = pick_gap(1'b1);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        base_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bases.size() == 0)
                report_mismatch("unexpected base", 64'(base_code), '0);
            else
            begin
                want = expected_bases.pop_front();
                if (base_code !== want.code)
                    report_mismatch("base_code", 64'(base_code), 64'(want.code));
                if (base_letter !== want.letter)
                    report_mismatch("base_letter", 64'(base_letter), 64'(want.letter));
            end
        end
    end

    function automatic logic [mdsg_pkg::SEED_W-1:0] splitmix_mix(
        logic [mdsg_pkg::SEED_W-1:0] z);
        z = (z ^ (z >> 30)) * mdsg_pkg::SM_MUL1;
        z = (z ^ (z >> 27)) * mdsg_pkg::SM_MUL2;
        return z ^ (z >> 31);
    endfunction

    function automatic void start_stream(logic [mdsg_pkg::WORD_W-1:0] idx);
        logic [mdsg_pkg::SEED_W-1:0] s;
        logic [mdsg_pkg::SEED_W-1:0] seed;
        logic [mdsg_pkg::SEED_W-1:0] v;
        s = seed_base + {32'd0, idx} + mdsg_pkg::SM_GAMMA;
        seed = splitmix_mix(s);
        for (int i = 0; i < mdsg_pkg::SEED_WORDS; i++)
        begin
            seed = seed + mdsg_pkg::SM_GAMMA;
            v = splitmix_mix(seed);
            rng_state[i] = v[31:0] ^ v[63:32];
        end
        if ((rng_state[0] | rng_state[1] | rng_state[2] | rng_state[3]) == '0)
            rng_state[0] = 32'd1;
        ctx_bits = '0;
        ctx_order = '0;
    endfunction

    function automatic void predict_base();
        logic [mdsg_pkg::ROW_W-1:0] row;
        logic [mdsg_pkg::WORD_W-1:0] w;
        logic [mdsg_pkg::WORD_W-1:0] t;
        logic [mdsg_pkg::BND_W-1:0] wx;
        logic [1:0] sym;
        base_t b;
        row = mdsg_pkg::ROW_START[ctx_order] + {1'b0, ctx_bits};
        if (row >= mdsg_pkg::TBL_ROWS)
            row = mdsg_pkg::ROW_W'(mdsg_pkg::TBL_ROWS - 1);
        // xoshiro128+ step
        w = rng_state[0] + rng_state[3];
        t = rng_state[1] << mdsg_pkg::XO_SHIFT;
        rng_state[2] ^= rng_state[0];
        rng_state[3] ^= rng_state[1];
        rng_state[1] ^= rng_state[2];
        rng_state[0] ^= rng_state[3];
        rng_state[2] ^= t;
        rng_state[3] = (rng_state[3] << mdsg_pkg::XO_ROT)
                     | (rng_state[3] >> (mdsg_pkg::WORD_W - mdsg_pkg::XO_ROT));
        wx = {1'b0, w};
        if (wx < bnd_tbl[row][1])
            sym = (wx < bnd_tbl[row][0]) ? 2'd0 : 2'd1;
        else
            sym = (wx < bnd_tbl[row][2]) ? 2'd2 : 2'd3;
        ctx_bits = {ctx_bits[2*mdsg_pkg::MAX_ORDER_DEF-3:0], sym};
        if (ctx_order < mdsg_pkg::MAX_ORDER_DEF)
            ctx_order++;
        b.code = sym;
        b.letter = LETTERS[8*(3-sym) +: 8];
        expected_bases = {expected_bases, b};
    endfunction

    function automatic logic [mdsg_pkg::BND_W-1:0] rand_bound();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return BND_FULL;
        return {1'b0, $urandom};
    endfunction

    function automatic logic [mdsg_pkg::WORD_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [mdsg_pkg::ROW_W-1:0] rand_row(int lo, int hi);
        return mdsg_pkg::ROW_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [mdsg_pkg::COL_W-1:0] rand_col(int lo, int hi);
        return mdsg_pkg::COL_W'($urandom_range(lo, hi));
    endfunction

    task automatic send_request(mdsg_pkg::mode_t m, logic [mdsg_pkg::ROW_W-1:0] row,
                                logic [mdsg_pkg::COL_W-1:0] col,
                                logic [mdsg_pkg::BND_W-1:0] bnd,
                                logic [mdsg_pkg::WORD_W-1:0] idx);
        int gap;
        in_valid <= 1'b1;
        mode <= m;
        table_row <= row;
        table_column <= col;
        boundary_value <= bnd;
        sequence_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        case (m)
            mdsg_pkg::MODE_WRITE:
                if (row < mdsg_pkg::TBL_ROWS && col < mdsg_pkg::TBL_COLS)
                    bnd_tbl[row][col] = bnd;
            mdsg_pkg::MODE_START: start_stream(idx);
            mdsg_pkg::MODE_GEN: predict_base();
            default: ;
        endcase
        gap = pick_gap(sender_idles);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_write(logic [mdsg_pkg::ROW_W-1:0] row,
                              logic [mdsg_pkg::COL_W-1:0] col,
                              logic [mdsg_pkg::BND_W-1:0] bnd);
        send_request(mdsg_pkg::MODE_WRITE, row, col, bnd, $urandom);
    endtask

    task automatic send_start(logic [mdsg_pkg::WORD_W-1:0] idx);
        send_request(mdsg_pkg::MODE_START, rand_row(0, 127), rand_col(0, 3), rand_bound(),
                     idx);
    endtask

    task automatic send_gen();
        send_request(mdsg_pkg::MODE_GEN, rand_row(0, 127), rand_col(0, 3), rand_bound(),
                     $urandom);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (expected_bases.size() != 0)
            @(posedge clk);
    endtask

    // starts produce no base, so give the seeder time to finish
    task automatic wait_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed_base(logic [mdsg_pkg::SEED_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        seed_base = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // zero generator words after reset give a zero draw
    task automatic test_generate_before_start();
        send_write(7'd0, 2'd0, '0);
        send_write(7'd0, 2'd1, BND_FULL);
        send_write(7'd0, 2'd2, BND_FULL);
        send_gen();
    endtask

    task automatic test_table_load();
        logic [mdsg_pkg::BND_W-1:0] b [3];
        logic [mdsg_pkg::BND_W-1:0] tmp;
        for (int row = 0; row < mdsg_pkg::TBL_ROWS; row++)
        begin
            for (int c = 0; c < mdsg_pkg::TBL_COLS; c++)
                b[c] = rand_bound();
            // mostly cumulative rows, some left unordered
            if ($urandom_range(0, 9) != 0)
            begin
                for (int p = 0; p < 2; p++)
                    for (int c = 0; c < 2 - p; c++)
                        if (b[c] > b[c+1])
                        begin
                            tmp = b[c];
                            b[c] = b[c+1];
                            b[c+1] = tmp;
                        end
            end
            for (int c = 0; c < mdsg_pkg::TBL_COLS; c++)
                send_write(mdsg_pkg::ROW_W'(row), mdsg_pkg::COL_W'(c), b[c]);
        end
    endtask

    task automatic test_special_cases();
        send_write(7'd85, 2'd0, rand_bound());
        send_write(7'd127, 2'd2, rand_bound());
        send_write(rand_row(0, mdsg_pkg::TBL_ROWS - 1), 2'd3, rand_bound());
        send_request(mdsg_pkg::MODE_NONE, rand_row(0, 127), rand_col(0, 3), rand_bound(),
                     $urandom);
        send_start('0);
        repeat (5) send_gen();
        for (int c = 0; c < mdsg_pkg::TBL_COLS; c++)
            send_write(7'd0, mdsg_pkg::COL_W'(c), '0);
        send_start($urandom);
        send_gen();
        for (int c = 0; c < mdsg_pkg::TBL_COLS; c++)
            send_write(7'd0, mdsg_pkg::COL_W'(c), BND_FULL);
        send_start($urandom);
        send_gen();
        // unordered boundaries in row 0
        send_write(7'd0, 2'd1, '0);
        send_start($urandom);
        send_gen();
        wait_idle();
        write_seed_base('1);
        send_start('1);
        repeat (2) send_gen();
    endtask

    task automatic send_noise(output bit counted);
        int r;
        r = $urandom_range(0, 9);
        counted = 1'b0;
        if (r < 6)
        begin
            send_write(rand_row(0, mdsg_pkg::TBL_ROWS - 1),
                       rand_col(0, mdsg_pkg::TBL_COLS - 1), rand_bound());
            counted = 1'b1;
        end
        else if (r < 8)
            send_write(rand_row(mdsg_pkg::TBL_ROWS, 127), rand_col(0, 3), rand_bound());
        else if (r < 9)
            send_write(rand_row(0, 127), 2'd3, rand_bound());
        else
            send_request(mdsg_pkg::MODE_NONE, rand_row(0, 127), rand_col(0, 3),
                         rand_bound(), $urandom);
    endtask

    task automatic test_random_streams();
        logic [mdsg_pkg::SEED_W-1:0] base_val;
        int done;
        int run_len;
        bit counted;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: base_val = '0;
                1: base_val = '1;
                default: base_val = {$urandom, $urandom};
            endcase
            wait_idle();
            write_seed_base(base_val);
            sender_idles = (phase != 1 && phase != 3);
            receiver_stalls = (phase != 1 && phase != 2);
            done = 0;
            while (done < RANDOM_ITEMS / 4)
            begin
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
                if ($urandom_range(0, 4) != 0)
                begin
                    send_start(pick_index());
                    done++;
                    run_len = $urandom_range(1, 24);
                    for (int k = 0; k < run_len; k++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            send_noise(counted);
                        else
                        begin
                            send_gen();
                            counted = 1'b1;
                        end
                        if (counted)
                            done++;
                    end
                end
                else
                begin
                    send_noise(counted);
                    if (counted)
                        done++;
                end
            end
        end
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial
    begin
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_seed_base({$urandom, $urandom});
        test_generate_before_start();
        test_table_load();
        test_special_cases();
        test_random_streams();
        in_valid <= 1'b0;
        waited = 0;
        while (expected_bases.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_bases.size() != 0)
            report_mismatch("bases never produced", 64'(expected_bases.size()), '0);
        if (mismatch_count == 0)
            $display("markov_dna_sequence_generator test passed");
        else
            $display("markov_dna_sequence_generator test failed");
        $finish;
    end

endmodule
